FILE: rtl/rcpa_pkg.sv
// package for the refcounted page allocator
// widths, operation and status codes, register indexes; no dependencies
package rcpa_pkg;

  localparam int unsigned ADDR_W         = 56;
  localparam int unsigned FUNC_W         = 3;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned NUM_PAGES_DEF  = 32768;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  localparam logic [ADDR_W-1:0] RST_REGION_BASE  = 56'd2147483648;
  localparam logic [ADDR_W-1:0] RST_REGION_TOP   = 56'd2281701376;
  localparam logic [ADDR_W-1:0] RST_FIRST_USABLE = 56'd2147483648;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_TOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT  = 3'd0,
    FUNC_ALLOC = 3'd1,
    FUNC_FREE  = 3'd2,
    FUNC_REF   = 3'd3,
    FUNC_UNREF = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OOM     = 2'd1,
    STATUS_IGNORED = 2'd2,
    STATUS_FAULT   = 2'd3
  } status_e;

  // address check result handed from the lookup to the control
  typedef struct packed {
    logic hit;     // aligned, inside the region and the pool
    logic fu_ok;   // at or above first_usable
  } lookup_t;

endpackage

FILE: rtl/refcounted_page_allocator.sv
// refcounted page allocator: free list and reference counts in two rams
// depends on rcpa_pkg, rcpa_ram, rcpa_lookup
//
// Usage:
// - input channel (in_valid_i/in_ready_o) carries func_i and page_addr_i;
//   output channel (out_valid_o/out_ready_i) returns one result transaction
//   per input transaction: result_addr_o, status_o, page_freed_o, ref_after_o
// - cfg_we_i/cfg_idx_i/cfg_data_i write one of region_base, region_top and
//   first_usable per write, chosen by cfg_idx_i; write only while the block is idle
// - alloc, free, ref, unref: the count and link rams are read in the accept
//   cycle and written back in ST_EXEC once the output register is free, where
//   the result is loaded; a new transaction is taken only after that step
// - init sweeps every page of the pool, one ram entry per cycle, clearing
//   counts and linking the usable pages; ST_DONE then returns the result
// - after reset the count ram is cleared entry by entry in ST_CLEAR; in_ready_o
//   stays low meanwhile, configuration writes are taken as usual
// - a result waits in the output register while the receiver stalls; the
//   next transaction is still accepted and holds in its write-back step
//   until the output register is free
module refcounted_page_allocator #(
  parameter int unsigned NUM_PAGES  = rcpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = rcpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcpa_pkg::ADDR_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rcpa_pkg::FUNC_W-1:0]    func_i,
  input  logic [rcpa_pkg::ADDR_W-1:0]    page_addr_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rcpa_pkg::ADDR_W-1:0]    result_addr_o,
  output logic [rcpa_pkg::STATUS_W-1:0]  status_o,
  output logic                           page_freed_o,
  output logic [rcpa_pkg::CNT_W-1:0]     ref_after_o
);
  import rcpa_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_PAGES);
  localparam int unsigned LNK_W = IDX_W + 1;
  localparam int unsigned PW    = ADDR_W + 1;
  localparam logic [ADDR_W-1:0] PgMask =
    {{(ADDR_W-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NUM_PAGES - 1);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_INIT_P = 7'b0001000,
    ST_INIT_C = 7'b0010000,
    ST_SWEEP  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] region_base_q, region_top_q, first_usable_q;
  logic [ADDR_W-1:0] base_al;

  logic [IDX_W-1:0] head_q, head_d;
  logic             nonempty_q, nonempty_d;
  logic [IDX_W-1:0] ctr_q, ctr_d;

  logic [FUNC_W-1:0] func_q;
  logic [IDX_W-1:0]  idx_q;
  lookup_t           look_q;

  logic [PW-1:0] p_q;
  logic [PW-1:0] start_q, whole_q;
  logic          topok_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           status_q, status_d;
  logic              freed_q, freed_d;
  logic [CNT_W-1:0]  after_q, after_d;
  logic              out_load;

  // lookup
  lookup_t          look;
  logic [IDX_W-1:0] look_idx;

  // rams
  logic             cnt_we, lnk_we, rd_en;
  logic [IDX_W-1:0] cnt_waddr, lnk_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic [LNK_W-1:0] lnk_wdata, lnk_rdata;

  // init calculations
  logic [PW-1:0] base_w, top_w, p_round, ctr_w;
  logic          in_rng;

  logic in_acc;

  assign base_al = region_base_q & ~PgMask;
  assign base_w  = {1'b0, base_al};
  assign top_w   = {1'b0, region_top_q};
  assign ctr_w   = PW'(ctr_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_load   = (state_q == ST_EXEC || state_q == ST_DONE)
                    && (!out_valid_q || out_ready_i);

  rcpa_lookup #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_lookup (
    .page_addr_i    (page_addr_i),
    .base_al_i      (base_al),
    .region_top_i   (region_top_q),
    .first_usable_i (first_usable_q),
    .res_o          (look),
    .idx_o          (look_idx)
  );

  // alloc works on the head, everything else on the addressed page
  assign cnt_raddr = (func_i == FUNC_ALLOC) ? head_q : look_idx;
  assign rd_en     = in_acc;

  rcpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_PAGES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (rd_en),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  rcpa_ram #(
    .WIDTH (LNK_W),
    .DEPTH (NUM_PAGES)
  ) u_lnk_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .re_i    (rd_en),
    .raddr_i (head_q),
    .rdata_o (lnk_rdata)
  );

  // init: first page address, rounded up and clamped to the base
  assign p_round = (({1'b0, first_usable_q}) + PW'(PgMask)) & ~PW'(PgMask);
  assign in_rng  = topok_q && (ctr_w >= start_q) && ((ctr_w - start_q) < whole_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    nonempty_d  = nonempty_q;
    ctr_d       = ctr_q;
    cnt_we      = 1'b0;
    cnt_waddr   = idx_q;
    cnt_wdata   = '0;
    lnk_we      = 1'b0;
    lnk_waddr   = idx_q;
    lnk_wdata   = {nonempty_q, head_q};
    out_valid_d = out_valid_q;
    res_addr_d  = '0;
    status_d    = STATUS_OK;
    freed_d     = 1'b0;
    after_d     = '0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = ctr_q;
        if (ctr_q == LastIdx) begin
          ctr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (func_i == FUNC_INIT) ? ST_INIT_P : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_load) begin
          state_d = ST_IDLE;
          case (func_q)
            FUNC_ALLOC: begin
              if (!nonempty_q) begin
                status_d = STATUS_OOM;
              end else begin
                head_d     = lnk_rdata[IDX_W-1:0];
                nonempty_d = lnk_rdata[IDX_W];
                cnt_we     = 1'b1;
                cnt_wdata  = CNT_W'(1);
                res_addr_d = base_al + (ADDR_W'(idx_q) << PAGE_SHIFT);
                after_d    = CNT_W'(1);
              end
            end
            FUNC_FREE: begin
              if (!(look_q.hit && look_q.fu_ok)) begin
                status_d = STATUS_FAULT;
              end else if (cnt_rdata != '0) begin
                after_d = cnt_rdata;
              end else begin
                lnk_we     = 1'b1;
                head_d     = idx_q;
                nonempty_d = 1'b1;
                freed_d    = 1'b1;
              end
            end
            FUNC_REF: begin
              if (!look_q.hit) begin
                status_d = STATUS_IGNORED;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
                after_d   = cnt_wdata;
              end
            end
            FUNC_UNREF: begin
              if (!look_q.hit) begin
                status_d = STATUS_IGNORED;
              end else if (cnt_rdata != '0) begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata - 1'b1;
                after_d   = cnt_wdata;
                // last reference gone: page goes back on the list
                if (cnt_wdata == '0) begin
                  lnk_we     = 1'b1;
                  head_d     = idx_q;
                  nonempty_d = 1'b1;
                  freed_d    = 1'b1;
                end
              end
            end
            default: begin
              status_d = STATUS_IGNORED;
            end
          endcase
          out_valid_d = 1'b1;
        end
      end
      ST_INIT_P: begin
        head_d     = '0;
        nonempty_d = 1'b0;
        ctr_d      = '0;
        state_d    = ST_INIT_C;
      end
      ST_INIT_C: begin
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        cnt_we    = 1'b1;
        cnt_waddr = ctr_q;
        lnk_waddr = ctr_q;
        if (in_rng) begin
          lnk_we     = 1'b1;
          head_d     = ctr_q;
          nonempty_d = 1'b1;
          // the first page pushed ends the list
          if (ctr_w == start_q) begin
            lnk_wdata = '0;
          end else begin
            lnk_wdata = {1'b1, IDX_W'(ctr_q - 1'b1)};
          end
        end
        if (ctr_q == LastIdx) begin
          ctr_d   = '0;
          state_d = ST_DONE;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      head_q         <= '0;
      nonempty_q     <= 1'b0;
      ctr_q          <= '0;
      out_valid_q    <= 1'b0;
      region_base_q  <= RST_REGION_BASE;
      region_top_q   <= RST_REGION_TOP;
      first_usable_q <= RST_FIRST_USABLE;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REGION_BASE:  region_base_q  <= cfg_data_i;
          CFG_REGION_TOP:   region_top_q   <= cfg_data_i;
          CFG_FIRST_USABLE: first_usable_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      idx_q  <= cnt_raddr;
      look_q <= look;
    end
    if (state_q == ST_INIT_P) begin
      p_q <= (p_round < base_w) ? base_w : p_round;
    end
    if (state_q == ST_INIT_C) begin
      start_q <= (p_q - base_w) >> PAGE_SHIFT;
      whole_q <= (top_w - p_q) >> PAGE_SHIFT;
      topok_q <= top_w >= p_q;
    end
    if (out_load) begin
      res_addr_q <= res_addr_d;
      status_q   <= status_d;
      freed_q    <= freed_d;
      after_q    <= after_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = res_addr_q;
  assign status_o      = status_q;
  assign page_freed_o  = freed_q;
  assign ref_after_o   = after_q;

endmodule

FILE: rtl/rcpa_ram.sv
// generic single-port-write, single-port-read ram with registered read
// depends on rcpa_pkg for default width and depth
module rcpa_ram #(
  parameter int unsigned WIDTH = rcpa_pkg::CNT_W,
  parameter int unsigned DEPTH = rcpa_pkg::NUM_PAGES_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rcpa_lookup.sv
// page address check: alignment, region bounds, pool size, first_usable
// depends on rcpa_pkg
module rcpa_lookup #(
  parameter int unsigned NUM_PAGES  = rcpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = rcpa_pkg::PAGE_SHIFT_DEF,
  localparam int unsigned IDX_W     = $clog2(NUM_PAGES)
) (
  input  logic [rcpa_pkg::ADDR_W-1:0] page_addr_i,
  input  logic [rcpa_pkg::ADDR_W-1:0] base_al_i,
  input  logic [rcpa_pkg::ADDR_W-1:0] region_top_i,
  input  logic [rcpa_pkg::ADDR_W-1:0] first_usable_i,
  output rcpa_pkg::lookup_t           res_o,
  output logic [IDX_W-1:0]            idx_o
);
  import rcpa_pkg::*;

  localparam logic [ADDR_W-1:0] PgMask =
    {{(ADDR_W-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};

  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-1:0] off;
  logic              aligned;
  logic              in_lo;
  logic              in_hi;
  logic              off_ok;

  always_comb begin
    aligned = (page_addr_i & PgMask) == '0;
    in_lo   = page_addr_i >= base_al_i;
    in_hi   = page_addr_i < region_top_i;
    diff    = page_addr_i - base_al_i;
    off     = diff >> PAGE_SHIFT;
    off_ok  = off < ADDR_W'(NUM_PAGES);
    res_o.hit   = aligned & in_lo & in_hi & off_ok;
    res_o.fu_ok = page_addr_i >= first_usable_i;
    idx_o       = off[IDX_W-1:0];
  end

endmodule
